[hw/rtl/acfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_pkg
// Types, codes and frame check functions shared by the frame checker modules.
// ----------------------------------------------------------------------------
package acfc_pkg;

    localparam int NUM_REF = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_SCAN  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_CRC  = 2'd2;
    localparam logic [1:0] ST_DROP = 2'd3;

    localparam logic [2:0] CFG_REF_FULL          = 3'd0;
    localparam logic [2:0] CFG_REF_THREE_QUARTER = 3'd1;
    localparam logic [2:0] CFG_REF_HALF          = 3'd2;
    localparam logic [2:0] CFG_REF_QUARTER       = 3'd3;
    localparam logic [2:0] CFG_REF_ZERO          = 3'd4;
    localparam logic [2:0] CFG_ERROR_LIMIT       = 3'd5;
    localparam logic [2:0] CFG_CHECK_PERIOD      = 3'd6;

    localparam logic [2:0] REF_FULL          = 3'd0;
    localparam logic [2:0] REF_THREE_QUARTER = 3'd1;
    localparam logic [2:0] REF_HALF          = 3'd2;
    localparam logic [2:0] REF_QUARTER       = 3'd3;
    localparam logic [2:0] REF_ZERO          = 3'd4;

    localparam logic [9:0] FULL_LO = 10'd758;
    localparam logic [9:0] TQ_LO   = 10'd503;
    localparam logic [9:0] TQ_HI   = 10'd776;
    localparam logic [9:0] HALF_LO = 10'd375;
    localparam logic [9:0] HALF_HI = 10'd648;
    localparam logic [9:0] QTR_LO  = 10'd247;
    localparam logic [9:0] QTR_HI  = 10'd520;
    localparam logic [9:0] ZERO_HI = 10'd264;

    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] ERR_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        OP_NOP        = 3'd0,
        OP_STORE      = 3'd1,
        OP_FRAME_ZERO = 3'd2,
        OP_FRAME_CRC  = 3'd3,
        OP_FRAME_DROP = 3'd4,
        OP_SCAN       = 3'd5,
        OP_READ       = 3'd6,
        OP_READ_DROP  = 3'd7
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  chan;
        logic [9:0]  sample;
    } t_item;

    typedef struct packed {
        logic [NUM_REF-1:0][4:0] ref_ch;
        logic [7:0]              error_limit;
        logic [7:0]              check_period;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] read_value;
        logic       comm_fault;
        logic [2:0] ref_failures;
        logic [7:0] error_count;
        logic       transfer_fault;
    } t_result;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] crc;
        crc = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            crc = crc[7] ? ((crc << 1) ^ CRC_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    function automatic logic [7:0] frame_crc(input logic [15:0] data);
        logic [7:0] crc;
        crc = crc_byte(CRC_INIT, data[15:8]);
        crc = crc_byte(crc, data[7:0]);
        return ~crc;
    endfunction

    function automatic logic ref_miss(input logic [2:0] k, input logic [9:0] v);
        logic miss;
        case (k)
            REF_FULL:          miss = (v < FULL_LO);
            REF_THREE_QUARTER: miss = (v < TQ_LO) || (v > TQ_HI);
            REF_HALF:          miss = (v < HALF_LO) || (v > HALF_HI);
            REF_QUARTER:       miss = (v < QTR_LO) || (v > QTR_HI);
            REF_ZERO:          miss = (v > ZERO_HI);
            default:           miss = 1'b0;
        endcase
        return miss;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/acfc_item_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_item_if
// Input channel: command, raw frame and read channel with valid/ready.
// ----------------------------------------------------------------------------
interface acfc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [23:0] raw_frame;
    logic [4:0]  read_channel;

    modport source (output valid, output command, output raw_frame, output read_channel,
                    input ready);
    modport sink   (input valid, input command, input raw_frame, input read_channel,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/acfc_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_result_if
// Result channel: check status, read sample and error state with valid/ready.
// ----------------------------------------------------------------------------
interface acfc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] read_value;
    logic       comm_fault;
    logic [2:0] ref_failures;
    logic [7:0] error_count;
    logic       transfer_fault;

    modport source (output valid, output status, output read_value, output comm_fault,
                    output ref_failures, output error_count, output transfer_fault,
                    input ready);
    modport sink   (input valid, input status, input read_value, input comm_fault,
                    input ref_failures, input error_count, input transfer_fault,
                    output ready);
endinterface
`default_nettype wire

[hw/rtl/acfc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_front
// Accepts input transactions, checks frame CRC and ranges, and issues an op.
// ----------------------------------------------------------------------------
module acfc_front #(
    parameter int CHANNELS = 18
) (
    acfc_item_if.sink          i_item,
    input  wire logic          i_full,
    output logic               o_push,
    output acfc_pkg::t_item    o_push_item
);
    import acfc_pkg::*;

    logic [15:0] data;
    logic [4:0]  id;
    logic        crc_bad;

    assign data    = i_item.raw_frame[23:8];
    assign id      = data[14:10];
    assign crc_bad = (i_item.raw_frame[7:0] != frame_crc(data));

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_push_item.op     = OP_NOP;
        o_push_item.chan   = id;
        o_push_item.sample = data[9:0];
        case (i_item.command)
            CMD_FRAME: begin
                if (i_item.raw_frame == 24'd0) begin
                    o_push_item.op = OP_FRAME_ZERO;
                end else if (crc_bad) begin
                    o_push_item.op = OP_FRAME_CRC;
                end else if (id <= 5'(CHANNELS)) begin
                    o_push_item.op = OP_STORE;
                end else begin
                    o_push_item.op = OP_FRAME_DROP;
                end
            end
            CMD_SCAN: begin
                o_push_item.op = OP_SCAN;
            end
            CMD_READ: begin
                o_push_item.chan = i_item.read_channel;
                o_push_item.op   = (i_item.read_channel <= 5'(CHANNELS)) ? OP_READ
                                                                        : OP_READ_DROP;
            end
            default: begin
                o_push_item.op = OP_NOP;
            end
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/acfc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_queue
// Two-entry queue between the classify front and the execute back end.
// ----------------------------------------------------------------------------
module acfc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  acfc_pkg::t_item      i_push_item,
    input  wire logic            i_pop,
    output acfc_pkg::t_item      o_pop_item,
    output logic                 o_full,
    output logic                 o_empty
);
    import acfc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_item = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/acfc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acfc_back
// Executes ops: sample store, reference self check, error and scan counters,
// and the registered result stage.
// ----------------------------------------------------------------------------
module acfc_back #(
    parameter int CHANNELS = 18
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  acfc_pkg::t_cfg      i_cfg,
    input  wire logic           i_empty,
    input  acfc_pkg::t_item     i_item,
    output logic                o_pop,
    acfc_result_if.source       o_result
);
    import acfc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS + 1) : 1;

    logic [9:0]       r_store [CHANNELS+1];
    logic [CHANNELS:0] r_miss [NUM_REF];
    logic [7:0]       r_err, n_err;
    logic [7:0]       r_scan, n_scan;
    logic             r_valid;
    t_result          r_res, n_res;

    logic             fire;
    logic [IDX_W-1:0] idx;
    logic [NUM_REF-1:0] chk_miss;
    logic [2:0]       misses;
    logic [2:0]       err_add;
    logic [8:0]       err_sum;

    assign fire  = !i_empty && (!r_valid || o_result.ready);
    assign o_pop = fire;
    assign idx   = i_item.chan[IDX_W-1:0];

    always_comb begin
        logic [CHANNELS:0] sel_hot;
        for (int k = 0; k < NUM_REF; k++) begin
            sel_hot = (CHANNELS + 1)'(1) << i_cfg.ref_ch[k];
            if (i_cfg.ref_ch[k] <= 5'(CHANNELS)) begin
                chk_miss[k] = |(r_miss[k] & sel_hot);
            end else begin
                chk_miss[k] = ref_miss(3'(k), 10'd0);
            end
        end
        misses = 3'($countones(chk_miss));
    end

    always_comb begin
        n_res                = '0;
        n_scan               = r_scan;
        err_add              = '0;
        case (i_item.op)
            OP_FRAME_ZERO: begin
                n_res.status     = ST_ZERO;
                n_res.comm_fault = 1'b1;
                err_add          = 3'd1;
            end
            OP_FRAME_CRC: begin
                n_res.status     = ST_CRC;
                n_res.comm_fault = 1'b1;
                err_add          = 3'd1;
            end
            OP_FRAME_DROP: begin
                n_res.status = ST_DROP;
            end
            OP_SCAN: begin
                if (r_scan >= i_cfg.check_period) begin
                    n_res.ref_failures = misses;
                    n_res.comm_fault   = (misses != 3'd0);
                    err_add            = misses;
                    n_scan             = '0;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            OP_READ: begin
                n_res.read_value = r_store[idx];
            end
            OP_READ_DROP: begin
                n_res.status = ST_DROP;
            end
            default: begin
                n_res = '0;
            end
        endcase
        err_sum              = {1'b0, r_err} + 9'(err_add);
        n_err                = err_sum[8] ? ERR_MAX : err_sum[7:0];
        n_res.error_count    = n_err;
        n_res.transfer_fault = (n_err >= i_cfg.error_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= '0;
            r_scan  <= '0;
            r_valid <= 1'b0;
            for (int c = 0; c <= CHANNELS; c++) begin
                r_store[c] <= '0;
            end
            for (int k = 0; k < NUM_REF; k++) begin
                r_miss[k] <= {(CHANNELS + 1){ref_miss(3'(k), 10'd0)}};
            end
        end else begin
            if (fire) begin
                r_err   <= n_err;
                r_scan  <= n_scan;
                r_valid <= 1'b1;
                if (i_item.op == OP_STORE) begin
                    r_store[idx] <= i_item.sample;
                    for (int k = 0; k < NUM_REF; k++) begin
                        r_miss[k][idx] <= ref_miss(3'(k), i_item.sample);
                    end
                end
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid          = r_valid;
    assign o_result.status         = r_res.status;
    assign o_result.read_value     = r_res.read_value;
    assign o_result.comm_fault     = r_res.comm_fault;
    assign o_result.ref_failures   = r_res.ref_failures;
    assign o_result.error_count    = r_res.error_count;
    assign o_result.transfer_fault = r_res.transfer_fault;

endmodule
`default_nettype wire

[hw/rtl/adc_frame_crc_checker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_frame_crc_checker_unit
// Converter frame checker: CRC-8 frame check, per-channel sample store,
// periodic reference self check and saturating error counting.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the queue is not full and returns
// exactly one result per transaction, in order. A transaction passes through
// the queue and then the registered result stage; the sustained rate of one
// transaction per cycle, with no result stall, is set by the execute stage
// behind a two-entry queue, and a stalled result holds in the output register
// while the queue takes transactions until full. Frames are checked with CRC-8
// (poly 0x1D, init 0xFF, complemented) over bits 23:8; good frames store bits
// 17:8 under channel id bits 22:18, ids above CHANNELS are dropped. The sample
// store resets to zero. Configuration registers (index: reset) are reference
// channels full 0:1, three-quarter 1:2, half 2:3, quarter 3:4, zero 4:5,
// error limit 5:10 and check period 6:10; write them only while idle.
// ----------------------------------------------------------------------------
module adc_frame_crc_checker_unit #(
    parameter int CHANNELS = 18
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    acfc_item_if.sink         i_item,
    acfc_result_if.source     o_result,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);
    import acfc_pkg::*;

    t_cfg   r_cfg;
    logic   push;
    t_item  push_item;
    t_item  pop_item;
    logic   pop;
    logic   full;
    logic   empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_ch[REF_FULL]          <= 5'd1;
            r_cfg.ref_ch[REF_THREE_QUARTER] <= 5'd2;
            r_cfg.ref_ch[REF_HALF]          <= 5'd3;
            r_cfg.ref_ch[REF_QUARTER]       <= 5'd4;
            r_cfg.ref_ch[REF_ZERO]          <= 5'd5;
            r_cfg.error_limit               <= 8'd10;
            r_cfg.check_period              <= 8'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REF_FULL:          r_cfg.ref_ch[REF_FULL]          <= i_cfg_data[4:0];
                CFG_REF_THREE_QUARTER: r_cfg.ref_ch[REF_THREE_QUARTER] <= i_cfg_data[4:0];
                CFG_REF_HALF:          r_cfg.ref_ch[REF_HALF]          <= i_cfg_data[4:0];
                CFG_REF_QUARTER:       r_cfg.ref_ch[REF_QUARTER]       <= i_cfg_data[4:0];
                CFG_REF_ZERO:          r_cfg.ref_ch[REF_ZERO]          <= i_cfg_data[4:0];
                CFG_ERROR_LIMIT:       r_cfg.error_limit               <= i_cfg_data;
                CFG_CHECK_PERIOD:      r_cfg.check_period              <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    acfc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_item      (i_item),
        .i_full      (full),
        .o_push      (push),
        .o_push_item (push_item)
    );

    acfc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_pop_item  (pop_item),
        .o_full      (full),
        .o_empty     (empty)
    );

    acfc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_empty  (empty),
        .i_item   (pop_item),
        .o_pop    (pop),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    a_transfer_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.transfer_fault == (o_result.error_count >= r_cfg.error_limit)))
        else $error("transfer fault disagrees with error count");

    a_ref_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.ref_failures != 3'd0)) |-> o_result.comm_fault)
        else $error("reference miss without communication fault");

    a_drop_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status == ST_DROP)) |-> !o_result.comm_fault)
        else $error("dropped transaction raised a fault");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("queue written while full");
`endif

endmodule
`default_nettype wire
